// File: hw/rtl/pcpa_pkg.sv
package pcpa_pkg;

	localparam int DEF_NUM_CPUS   = 8;
	localparam int DEF_NUM_PAGES  = 32768;
	localparam int DEF_PAGE_BYTES = 4096;

	localparam int ADDR_W      = 32;
	localparam int CPU_FIELD_W = 3;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'd2147614720;
	localparam logic [ADDR_W-1:0] MEMORY_TOP_RST = 32'd2281701376;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OOM      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_FREE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEMORY_TOP = 1'd1;

	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
	} alu_req_t;

endpackage

// File: hw/rtl/pcpa_alu.sv
// Shared 33-bit add/subtract; bit ADDR_W is carry on add, borrow on subtract.
module pcpa_alu
	import pcpa_pkg::*;
(
	input  alu_req_t          req,
	output logic [ADDR_W:0]   res
);

	always_comb begin
		if (req.op == ALU_SUB) begin
			res = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			res = {1'b0, req.a} + {1'b0, req.b};
		end
	end

endmodule

// File: hw/rtl/pcpa_link_mem.sv
module pcpa_link_mem
	import pcpa_pkg::*;
#(
	parameter int DEPTH  = DEF_NUM_PAGES,
	parameter int AW     = $clog2(DEF_NUM_PAGES),
	parameter int DW     = $clog2(DEF_NUM_PAGES) + 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/per_cpu_page_free_list_allocator.sv
// Per-CPU LIFO page free lists with stealing. A free (opcode 1) checks that the
// address is page aligned, >= kernel_end, < memory_top and within NUM_PAGES pages
// of the kernel_end page, then pushes it on the list of cpu (taken modulo
// NUM_CPUS); a bad address returns status 2. An alloc (opcode 0) pops the
// caller's list, else the lowest-numbered non-empty list, else returns address 0
// with status 1. One transaction is in flight at a time: in_ready is high only
// while the sequencer is idle. A free runs the lower-bound and alignment check,
// the upper-bound check, the slot computation and the range check, and stops at
// the first check that fails; an alloc picks a list and then pops it, unless
// every list is empty. Each transaction then waits in the output state until the
// output register is free. The steps follow from the single 33-bit adder that
// does every bound check, slot computation and address build in turn, and from
// the registered read of the next-page link memory. Links hold no reset value and
// need no clearing pass; after reset every list is empty. Configuration writes are
// always accepted and are meant to arrive while no transaction is pending.
module per_cpu_page_free_list_allocator
	import pcpa_pkg::*;
#(
	parameter int NUM_CPUS   = DEF_NUM_CPUS,
	parameter int NUM_PAGES  = DEF_NUM_PAGES,
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   opcode,
	input  logic [CPU_FIELD_W-1:0] cpu,
	input  logic [ADDR_W-1:0]      page_address,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ADDR_W-1:0]      alloc_address,
	output logic [STATUS_W-1:0]    status
);

	localparam int CPU_IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int SLOT_W = $clog2(NUM_PAGES);
	localparam int PG_SH  = $clog2(PAGE_BYTES);
	localparam int PN_W   = ADDR_W - PG_SH;
	localparam int LINK_W = SLOT_W + 1;
	localparam logic [4:0] NC5 = 5'(NUM_CPUS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHK_LO = 3'd1;
	localparam logic [2:0] ST_CHK_HI = 3'd2;
	localparam logic [2:0] ST_SLOT   = 3'd3;
	localparam logic [2:0] ST_RANGE  = 3'd4;
	localparam logic [2:0] ST_ALLOC  = 3'd5;
	localparam logic [2:0] ST_POP    = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0]              state_q;
	logic [ADDR_W-1:0]       kernel_end_q;
	logic [ADDR_W-1:0]       memory_top_q;
	logic [NUM_CPUS-1:0]     nonempty_q;
	logic [SLOT_W-1:0]       head_q [NUM_CPUS];

	logic                    op_q;
	logic [CPU_IW-1:0]       cpu_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [PN_W-1:0]         page_q;
	logic [CPU_IW-1:0]       sel_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [ADDR_W-1:0]       res_addr_q;
	logic [STATUS_W-1:0]     res_status_q;

	logic                    out_valid_q;
	logic [ADDR_W-1:0]       out_addr_q;
	logic [STATUS_W-1:0]     out_status_q;

	logic [4:0]              cpu_mod;
	logic [CPU_IW-1:0]       steal_sel;
	logic [CPU_IW-1:0]       pick_sel;
	logic                    any_ne;
	logic [CPU_IW-1:0]       head_idx;
	logic [SLOT_W-1:0]       head_rd;

	alu_req_t                alu_req;
	logic [ADDR_W:0]         alu_res;
	logic                    borrow;

	logic                    push_en;
	logic [SLOT_W-1:0]       push_slot;
	logic                    rd_en;
	logic [LINK_W-1:0]       link_rd;
	logic                    out_load;
	logic                    accept;

	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == ST_IDLE);
	assign accept        = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign alloc_address = out_addr_q;
	assign status        = out_status_q;

	// cpu modulo NUM_CPUS by repeated subtraction; cpu is only 3 bits
	always_comb begin
		cpu_mod = {2'b00, cpu};
		for (int i = 0; i < 8; i++) begin
			if (cpu_mod >= NC5) begin
				cpu_mod = cpu_mod - NC5;
			end
		end
	end

	// lowest-numbered non-empty list
	always_comb begin
		steal_sel = '0;
		for (int i = NUM_CPUS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				steal_sel = CPU_IW'(i);
			end
		end
	end

	assign any_ne   = |nonempty_q;
	assign pick_sel = nonempty_q[cpu_q] ? cpu_q : steal_sel;
	assign head_idx = (state_q == ST_ALLOC) ? pick_sel : cpu_q;
	assign head_rd  = head_q[head_idx];

	always_comb begin
		alu_req.op = ALU_SUB;
		alu_req.a  = addr_q;
		alu_req.b  = kernel_end_q;
		case (state_q)
			ST_CHK_LO: begin
				alu_req.b = kernel_end_q;
			end
			ST_CHK_HI: begin
				alu_req.b = memory_top_q;
			end
			ST_SLOT: begin
				alu_req.a = addr_q >> PG_SH;
				alu_req.b = kernel_end_q >> PG_SH;
			end
			ST_RANGE: begin
				alu_req.a = ADDR_W'(page_q);
				alu_req.b = ADDR_W'(NUM_PAGES);
			end
			ST_POP: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = kernel_end_q >> PG_SH;
				alu_req.b  = ADDR_W'(slot_q);
			end
			default: begin
				alu_req.op = ALU_SUB;
			end
		endcase
	end

	pcpa_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	assign borrow    = alu_res[ADDR_W];
	assign push_slot = SLOT_W'(page_q);
	assign push_en   = (state_q == ST_RANGE) && borrow;
	assign rd_en     = (state_q == ST_ALLOC) && any_ne;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	pcpa_link_mem #(
		.DEPTH (NUM_PAGES),
		.AW    (SLOT_W),
		.DW    (LINK_W)
	) u_link_mem (
		.clk   (clk),
		.we    (push_en),
		.waddr (push_slot),
		.wdata ({nonempty_q[cpu_q], head_rd}),
		.re    (rd_en),
		.raddr (head_rd),
		.rdata (link_rd)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kernel_end_q <= KERNEL_END_RST;
			memory_top_q <= MEMORY_TOP_RST;
			nonempty_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_KERNEL_END: kernel_end_q <= cfg_data;
					REG_MEMORY_TOP: memory_top_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (opcode == OP_FREE) ? ST_CHK_LO : ST_ALLOC;
					end
				end
				ST_CHK_LO: begin
					if (borrow || (addr_q[PG_SH-1:0] != '0)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_CHK_HI;
					end
				end
				ST_CHK_HI: begin
					state_q <= borrow ? ST_SLOT : ST_OUT;
				end
				ST_SLOT: begin
					state_q <= ST_RANGE;
				end
				ST_RANGE: begin
					if (push_en) begin
						nonempty_q[cpu_q] <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_ALLOC: begin
					state_q <= any_ne ? ST_POP : ST_OUT;
				end
				ST_POP: begin
					if (!link_rd[SLOT_W]) begin
						nonempty_q[sel_q] <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			cpu_q  <= CPU_IW'(cpu_mod);
			addr_q <= page_address;
		end
		if (state_q == ST_SLOT) begin
			page_q <= alu_res[PN_W-1:0];
		end
		if (push_en) begin
			head_q[cpu_q] <= push_slot;
		end
		if (rd_en) begin
			sel_q  <= pick_sel;
			slot_q <= head_rd;
		end
		if ((state_q == ST_POP) && link_rd[SLOT_W]) begin
			head_q[sel_q] <= link_rd[SLOT_W-1:0];
		end

		case (state_q)
			ST_CHK_LO: begin
				res_addr_q   <= '0;
				res_status_q <= STAT_BAD_FREE;
			end
			ST_RANGE: begin
				res_status_q <= borrow ? STAT_OK : STAT_BAD_FREE;
			end
			ST_ALLOC: begin
				res_addr_q   <= '0;
				res_status_q <= STAT_OOM;
			end
			ST_POP: begin
				res_addr_q   <= {alu_res[PN_W-1:0], {PG_SH{1'b0}}};
				res_status_q <= STAT_OK;
			end
			default: ;
		endcase

		if (out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	a_oom_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q != STAT_OK) |-> out_addr_q == '0)
		else $error("failed transaction carries a nonzero address");

	a_push_sets_list: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |=> nonempty_q[$past(cpu_q)])
		else $error("list still empty after push");

	a_pop_follows_pick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP |-> $past(state_q) == ST_ALLOC && $past(any_ne))
		else $error("pop without a non-empty list picked");

	a_free_is_free_op: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHK_LO |-> op_q == OP_FREE)
		else $error("address check on an alloc transaction");

endmodule

// File: verif/per_cpu_page_free_list_allocator_checker.sv
module per_cpu_page_free_list_allocator_checker
	import pcpa_pkg::*;
#(
	parameter int NUM_CPUS   = DEF_NUM_CPUS,
	parameter int NUM_PAGES  = DEF_NUM_PAGES,
	parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic                   opcode,
	input  logic [CPU_FIELD_W-1:0] cpu,
	input  logic [ADDR_W-1:0]      page_address,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [ADDR_W-1:0]      alloc_address,
	input  logic [STATUS_W-1:0]    status,
	output int                     mismatch_count,
	output int                     pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_W = $clog2(NUM_PAGES);
	localparam logic [ADDR_W-1:0] PAGE_SZ = PAGE_BYTES;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] stat;
	} page_reply_t;

	logic [ADDR_W-1:0] kernel_end_q;
	logic [ADDR_W-1:0] memory_top_q;
	logic [SLOT_W-1:0] link_slot [NUM_PAGES];
	logic              link_live [NUM_PAGES];
	logic [SLOT_W-1:0] list_top [NUM_CPUS];
	logic              list_busy [NUM_CPUS];
	page_reply_t       queued_replies [$];
	int                errs = 0;

	function automatic logic [ADDR_W-1:0] slot_address(input logic [SLOT_W-1:0] slot);
		logic [ADDR_W-1:0] pg;
		pg = kernel_end_q / PAGE_SZ + ADDR_W'(slot);
		return pg * PAGE_SZ;
	endfunction

	task automatic pop_page(input int c, output logic [ADDR_W-1:0] addr);
		logic [SLOT_W-1:0] slot;
		slot = list_top[c];
		if (link_live[slot]) begin
			list_top[c] = link_slot[slot];
		end else begin
			list_busy[c] = 1'b0;
		end
		addr = slot_address(slot);
	endtask

	task automatic model_page_op(input logic op, input logic [CPU_FIELD_W-1:0] cpu_f,
			input logic [ADDR_W-1:0] addr, output page_reply_t r);
		int c;
		bit found;
		logic [ADDR_W-1:0] slot32;
		c = int'(cpu_f) % NUM_CPUS;
		found = 1'b0;
		r.addr = '0;
		r.stat = STAT_OK;
		if (op == OP_FREE) begin
			slot32 = addr / PAGE_SZ - kernel_end_q / PAGE_SZ;
			if ((addr % PAGE_SZ) != 0 || addr < kernel_end_q || addr >= memory_top_q ||
					slot32 >= NUM_PAGES) begin
				r.stat = STAT_BAD_FREE;
			end else begin
				link_live[slot32] = list_busy[c];
				link_slot[slot32] = list_busy[c] ? list_top[c] : '0;
				list_top[c] = SLOT_W'(slot32);
				list_busy[c] = 1'b1;
			end
		end else if (list_busy[c]) begin
			pop_page(c, r.addr);
		end else begin
			// steal from the lowest-numbered list that has a page
			for (int i = 0; i < NUM_CPUS; i++) begin
				if (!found && list_busy[i]) begin
					found = 1'b1;
					pop_page(i, r.addr);
				end
			end
			if (!found)
				r.stat = STAT_OOM;
		end
	endtask

	task automatic note_failure(input page_reply_t want, input bit orphan);
		errs++;
		if (errs <= 10) begin
			if (orphan)
				$display("%0t: result with no transaction outstanding: addr %h status %0d",
					$realtime, alloc_address, status);
			else
				$display("%0t: mismatch: expected addr %h status %0d, got addr %h status %0d",
					$realtime, want.addr, want.stat, alloc_address, status);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		page_reply_t want;
		if (!arst_n) begin
			kernel_end_q = KERNEL_END_RST;
			memory_top_q = MEMORY_TOP_RST;
			for (int i = 0; i < NUM_CPUS; i++)
				list_busy[i] = 1'b0;
			queued_replies.delete();
			pending_count <= 0;
			mismatch_count <= errs;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KERNEL_END: kernel_end_q = cfg_data;
					REG_MEMORY_TOP: memory_top_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				model_page_op(opcode, cpu, page_address, want);
				queued_replies.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (queued_replies.size() == 0) begin
					want = '0;
					note_failure(want, 1'b1);
				end else begin
					want = queued_replies.pop_front();
					if (alloc_address !== want.addr || status !== want.stat)
						note_failure(want, 1'b0);
				end
			end
			pending_count <= queued_replies.size();
			mismatch_count <= errs;
		end
	end

endmodule

// File: verif/per_cpu_page_free_list_allocator_tb.sv
module per_cpu_page_free_list_allocator_tb
	import pcpa_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_PCT     = 13;
	localparam int PB           = DEF_PAGE_BYTES;
	localparam int NPAGES       = DEF_NUM_PAGES;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [ADDR_W-1:0]      cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   opcode;
	logic [CPU_FIELD_W-1:0] cpu;
	logic [ADDR_W-1:0]      page_address;
	logic                   out_valid;
	logic                   out_ready;
	logic [ADDR_W-1:0]      alloc_address;
	logic [STATUS_W-1:0]    status;
	int                     mismatch_count;
	int                     pending_count;

	bit                steady = 1'b0;
	int                hold_req_cnt = 0;
	int                cycle_cnt = 0;
	logic [ADDR_W-1:0] cur_ke = KERNEL_END_RST;
	logic [ADDR_W-1:0] cur_mt = MEMORY_TOP_RST;

	per_cpu_page_free_list_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.cpu           (cpu),
		.page_address  (page_address),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.alloc_address (alloc_address),
		.status        (status)
	);

	per_cpu_page_free_list_allocator_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.cpu            (cpu),
		.page_address   (page_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.alloc_address  (alloc_address),
		.status         (status),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("per_cpu_page_free_list_allocator_tb failed");
			$finish;
		end
	end

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		int hold_seen;
		hold_seen = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req_cnt != hold_seen) begin
				hold_seen = hold_req_cnt;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// random page inside the legal free window; small offsets favor repeat frees
	function automatic bit pick_valid(output logic [ADDR_W-1:0] a, input bit wide);
		longint unsigned lo, hi, lim, pg, span;
		a = $urandom();
		if (cur_mt == 0)
			return 1'b0;
		lo = cur_ke;
		lo = (lo + PB - 1) / PB;
		hi = cur_ke;
		hi = hi / PB + NPAGES - 1;
		lim = cur_mt;
		lim = (lim - 1) / PB;
		if (lim < hi)
			hi = lim;
		if (lo > hi)
			return 1'b0;
		span = hi - lo;
		if (!wide && span > 47)
			span = 47;
		pg = lo + $urandom_range(0, int'(span));
		a = ADDR_W'(pg * PB);
		return 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] bad_address();
		logic [ADDR_W-1:0] a;
		longint unsigned v;
		int kind;
		a = $urandom();
		kind = $urandom_range(4);
		case (kind)
			0: begin
				if (pick_valid(a, 1'b1))
					a = a + ADDR_W'($urandom_range(1, PB - 1));
			end
			1: begin
				if (cur_ke != 0)
					a = cur_ke - ADDR_W'($urandom_range(1, cur_ke < 65536 ? int'(cur_ke) : 65536));
			end
			2: begin
				v = cur_mt;
				v = v + longint'($urandom_range(0, 3)) * PB;
				if (v <= 64'hFFFF_FFFF)
					a = ADDR_W'(v);
			end
			3: begin
				// just past the last slot the link store can hold
				v = cur_ke;
				v = (v / PB + NPAGES + $urandom_range(0, 3)) * PB;
				if (v <= 64'hFFFF_FFFF)
					a = ADDR_W'(v);
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic send_item(input logic op, input logic [CPU_FIELD_W-1:0] c,
			input logic [ADDR_W-1:0] addr);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		cpu          <= c;
		page_address <= addr;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_window(input logic [ADDR_W-1:0] ke, input logic [ADDR_W-1:0] mt);
		wait_drained();
		write_reg(REG_KERNEL_END, ke);
		write_reg(REG_MEMORY_TOP, mt);
		cfg_valid <= 1'b0;
		cur_ke = ke;
		cur_mt = mt;
	endtask

	task automatic random_item(input bit fill);
		int r;
		logic [ADDR_W-1:0] a;
		logic [CPU_FIELD_W-1:0] c;
		r = $urandom_range(99);
		c = CPU_FIELD_W'($urandom_range(7));
		a = $urandom();
		if (r < (fill ? 55 : 15)) begin
			void'(pick_valid(a, $urandom_range(3) == 0));
			send_item(OP_FREE, c, a);
		end else if (r < 88) begin
			send_item(OP_ALLOC, c, a);
		end else begin
			send_item(OP_FREE, c, bad_address());
		end
	endtask

	// alternate fill-heavy and drain-heavy stretches so lists empty and refill
	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			random_item(((i / 40) % 2) == 0);
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_KERNEL_END;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		opcode       <= OP_ALLOC;
		cpu          <= '0;
		page_address <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_window(KERNEL_END_RST, MEMORY_TOP_RST);
		send_item(OP_ALLOC, 0, 0);
		send_item(OP_FREE, 0, KERNEL_END_RST);
		send_item(OP_FREE, 7, MEMORY_TOP_RST - PB);
		send_item(OP_FREE, 1, MEMORY_TOP_RST);
		send_item(OP_FREE, 1, KERNEL_END_RST - PB);
		send_item(OP_FREE, 1, KERNEL_END_RST + 1);
		send_item(OP_FREE, 1, 32'h0000_0000);
		send_item(OP_FREE, 1, 32'hFFFF_FFFF);
		send_item(OP_ALLOC, 7, 32'hFFFF_FFFF);
		send_item(OP_ALLOC, 3, 0);
		send_item(OP_ALLOC, 5, 0);
		// same page freed onto two lists: they end up sharing a tail
		send_item(OP_FREE, 2, KERNEL_END_RST + 5 * PB);
		send_item(OP_FREE, 2, KERNEL_END_RST + 9 * PB);
		send_item(OP_FREE, 4, KERNEL_END_RST + 5 * PB);
		send_item(OP_ALLOC, 2, 0);
		send_item(OP_ALLOC, 2, 0);
		send_item(OP_ALLOC, 2, 0);
		send_item(OP_ALLOC, 6, 0);
		send_item(OP_FREE, 6, KERNEL_END_RST + 20 * PB);
		send_item(OP_FREE, 5, KERNEL_END_RST + 21 * PB);
		send_item(OP_ALLOC, 1, 0);
		send_item(OP_ALLOC, 0, 0);
		run_random(250);
		hold_req_cnt++;
		run_random(250);

		set_window(32'h0000_0000, 32'hFFFF_FFFF);
		run_random(300);

		steady = 1'b1;
		set_window(32'hF800_0000, 32'hFFFF_FFFF);
		run_random(300);
		steady = 1'b0;

		// every free rejected; listed pages come back with wrapped addresses
		set_window(32'hFFFF_FFFF, 32'h0000_0000);
		run_random(200);

		set_window(32'h0001_2345, 32'h0020_0800);
		run_random(200);
		wait_drained();
		run_random(200);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("per_cpu_page_free_list_allocator_tb passed");
		else
			$display("per_cpu_page_free_list_allocator_tb failed");
		$finish;
	end

endmodule
